// ===== sv/csa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity accumulator package
// Widths, transfer types and the control groups passed between the units.
// ----------------------------------------------------------------------------
package csa_pkg;

    localparam int IN_W         = 16;
    localparam int ELEM_BITS    = 16;
    localparam int MAX_LEN_LOG2 = 17;
    localparam int FRAC_BITS    = 16;

    localparam int SQ_W    = 2 * ELEM_BITS + MAX_LEN_LOG2 - 1;
    localparam int DOT_W   = SQ_W + 1;
    localparam int OUT_W   = FRAC_BITS + 2;
    localparam int MUL_W   = DOT_W;
    localparam int LIMB_W  = (MUL_W + 1) / 2;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int P_W     = 2 * SQ_W;
    localparam int Q_W     = 2 * FRAC_BITS + 2;
    localparam int S_W     = FRAC_BITS + 1;
    localparam int CNT_W   = $clog2(Q_W);
    localparam int SUB_W   = PROD_W;
    localparam int SIM_ONE = 1 << FRAC_BITS;

    typedef struct packed {
        logic signed [IN_W-1:0] a_elem;
        logic signed [IN_W-1:0] b_elem;
        logic                   last_elem;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] similarity;
        logic                    zero_norm;
    } t_out_item;

    typedef struct packed {
        logic                    start;
        logic signed [DOT_W-1:0] dot;
        logic [SQ_W-1:0]         sa;
        logic [SQ_W-1:0]         sb;
    } t_acc_res;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] x;
        logic [MUL_W-1:0] y;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } t_mul_rsp;

endpackage

// ===== sv/csa_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity accumulator - element accumulator
// Sums the dot product and both sums of squares, one element pair per cycle
// when taken, handing the totals to the normalise sequencer on the final pair.
// ----------------------------------------------------------------------------
module csa_accum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  csa_pkg::t_in_item i_item,
    output csa_pkg::t_acc_res o_res
);
    import csa_pkg::*;

    logic signed [ELEM_BITS-1:0]   a;
    logic signed [ELEM_BITS-1:0]   b;
    logic signed [2*ELEM_BITS-1:0] aa;
    logic signed [2*ELEM_BITS-1:0] bb;
    logic signed [2*ELEM_BITS-1:0] ab;
    logic signed [DOT_W-1:0]       r_dot;
    logic signed [DOT_W-1:0]       n_dot;
    logic [SQ_W-1:0]               r_sa;
    logic [SQ_W-1:0]               n_sa;
    logic [SQ_W-1:0]               r_sb;
    logic [SQ_W-1:0]               n_sb;
    t_acc_res                      r_res;

    always_comb begin
        a     = i_item.a_elem[ELEM_BITS-1:0];
        b     = i_item.b_elem[ELEM_BITS-1:0];
        aa    = a * a;
        bb    = b * b;
        ab    = a * b;
        n_sa  = r_sa + SQ_W'($unsigned(aa));
        n_sb  = r_sb + SQ_W'($unsigned(bb));
        n_dot = r_dot + DOT_W'(ab);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot       <= '0;
            r_sa        <= '0;
            r_sb        <= '0;
            r_res.start <= 1'b0;
        end else begin
            r_res.start <= i_take && i_item.last_elem;
            if (i_take) begin
                if (i_item.last_elem) begin
                    r_res.dot   <= n_dot;
                    r_res.sa    <= n_sa;
                    r_res.sb    <= n_sb;
                    r_dot       <= '0;
                    r_sa        <= '0;
                    r_sb        <= '0;
                end else begin
                    r_dot <= n_dot;
                    r_sa  <= n_sa;
                    r_sb  <= n_sb;
                end
            end
        end
    end

    assign o_res = r_res;

endmodule

// ===== sv/csa_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity accumulator - limb multiplier
// Wide unsigned product built from four half-width partial products,
// one partial product a cycle, each added in the cycle after it is formed.
// ----------------------------------------------------------------------------
module csa_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csa_pkg::t_mul_req i_req,
    output csa_pkg::t_mul_rsp o_rsp
);
    import csa_pkg::*;

    localparam int MUL_STEPS = 4;
    localparam int MC_W      = $clog2(MUL_STEPS + 1);

    logic [MUL_W-1:0]    r_x;
    logic [MUL_W-1:0]    r_y;
    logic [MC_W-1:0]     r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [2*LIMB_W-1:0] r_pp;
    logic [1:0]          r_pk;
    logic [PROD_W-1:0]   r_acc;
    logic [2*LIMB_W-1:0] x_pad;
    logic [2*LIMB_W-1:0] y_pad;
    logic [LIMB_W-1:0]   xl;
    logic [LIMB_W-1:0]   yl;
    logic [2*LIMB_W-1:0] pp;
    logic [PROD_W-1:0]   pp_sh;

    always_comb begin
        x_pad = (2*LIMB_W)'(r_x);
        y_pad = (2*LIMB_W)'(r_y);
        xl    = r_cnt[1] ? x_pad[2*LIMB_W-1:LIMB_W] : x_pad[LIMB_W-1:0];
        yl    = r_cnt[0] ? y_pad[2*LIMB_W-1:LIMB_W] : y_pad[LIMB_W-1:0];
        pp    = xl * yl;
        unique case (r_pk)
            2'd0:    pp_sh = PROD_W'(r_pp);
            2'd1,
            2'd2:    pp_sh = PROD_W'(r_pp) << LIMB_W;
            default: pp_sh = PROD_W'(r_pp) << (2 * LIMB_W);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == MC_W'(MUL_STEPS));
            if (i_req.start) begin
                r_x    <= i_req.x;
                r_y    <= i_req.y;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == MC_W'(MUL_STEPS)) begin
                    r_acc  <= r_acc + pp_sh;
                    r_busy <= 1'b0;
                end else begin
                    r_pp  <= pp;
                    r_pk  <= r_cnt[1:0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt != '0) begin
                        r_acc <= r_acc + pp_sh;
                    end
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

// ===== sv/csa_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity accumulator - normalise sequencer
// Multiplies the two sums of squares and squares the dot product on the limb
// multiplier, then runs a shift-subtract divide and a digit-by-digit square
// root on one subtractor and rounds it into the signed fixed-point result.
// ----------------------------------------------------------------------------
module csa_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csa_pkg::t_acc_res  i_acc,
    output csa_pkg::t_mul_req  o_mul,
    input  csa_pkg::t_mul_rsp  i_mul,
    output logic               o_busy,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output csa_pkg::t_out_item o_out_data
);
    import csa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_D,
        ST_CMP,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } t_state;

    t_state            r_state;
    logic              r_neg;
    logic              r_zero;
    logic [SQ_W-1:0]   r_sa;
    logic [SQ_W-1:0]   r_sb;
    logic [DOT_W-1:0]  r_mag;
    logic [P_W-1:0]    r_p;
    logic [PROD_W-1:0] r_d2;
    logic [Q_W-1:0]    r_y;
    logic [S_W+1:0]    r_srem;
    logic [S_W-1:0]    r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic [S_W-1:0]    r_q;
    logic              r_mul_start;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [S_W+1:0]    sq_pre;
    logic [S_W+1:0]    sq_trial;
    logic [S_W-1:0]    sq_root_n;
    logic [S_W:0]      sq_round;
    logic [SUB_W-1:0]  sub_x;
    logic [SUB_W-1:0]  sub_y;
    logic [SUB_W:0]    sub_full;
    logic              sub_ge;
    logic [SUB_W-1:0]  sub_diff;
    logic [OUT_W-1:0]  q_ext;
    logic [OUT_W-1:0]  sim;
    logic              mul_go;

    always_comb begin
        sq_pre    = {r_srem[S_W-1:0], r_y[Q_W-1 -: 2]};
        sq_trial  = {1'b0, r_root[S_W-2:0], 2'b01};
        sub_x     = '0;
        sub_y     = '0;
        unique case (r_state)
            ST_CMP: begin
                sub_x = r_d2;
                sub_y = SUB_W'(r_p);
            end
            ST_DIV: begin
                sub_x = {r_d2[SUB_W-2:0], 1'b0};
                sub_y = SUB_W'(r_p);
            end
            ST_SQRT: begin
                sub_x = SUB_W'(sq_pre);
                sub_y = SUB_W'(sq_trial);
            end
            default: ;
        endcase
        sub_full  = {1'b0, sub_x} - {1'b0, sub_y};
        sub_ge    = !sub_full[SUB_W];
        sub_diff  = sub_full[SUB_W-1:0];
        sq_root_n = {r_root[S_W-2:0], sub_ge};
        sq_round  = {1'b0, sq_root_n} + (S_W+1)'(1);
        q_ext     = {1'b0, r_q};
        sim       = r_neg ? (~q_ext + OUT_W'(1)) : q_ext;
        mul_go    = ((r_state == ST_IDLE) && i_acc.start
                     && (i_acc.sa != '0) && (i_acc.sb != '0))
                    || ((r_state == ST_MUL_P) && i_mul.done);
    end

    always_comb begin
        o_mul.start = r_mul_start;
        o_mul.x     = (r_state == ST_MUL_D) ? r_mag : MUL_W'(r_sa);
        o_mul.y     = (r_state == ST_MUL_D) ? r_mag : MUL_W'(r_sb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mul_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_start <= mul_go;
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_acc.start) begin
                        r_sa   <= i_acc.sa;
                        r_sb   <= i_acc.sb;
                        r_neg  <= i_acc.dot[DOT_W-1];
                        r_mag  <= i_acc.dot[DOT_W-1] ? DOT_W'(-i_acc.dot) : i_acc.dot;
                        r_zero <= (i_acc.sa == '0) || (i_acc.sb == '0);
                        r_q    <= '0;
                        if ((i_acc.sa == '0) || (i_acc.sb == '0)) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_MUL_P;
                        end
                    end
                end
                ST_MUL_P: begin
                    if (i_mul.done) begin
                        r_p     <= i_mul.prod[P_W-1:0];
                        r_state <= ST_MUL_D;
                    end
                end
                ST_MUL_D: begin
                    if (i_mul.done) begin
                        r_d2    <= i_mul.prod;
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (sub_ge) begin
                        r_q     <= S_W'(1) << FRAC_BITS;
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt   <= CNT_W'(Q_W - 1);
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_d2 <= sub_ge ? sub_diff : {r_d2[SUB_W-2:0], 1'b0};
                    r_y  <= {r_y[Q_W-2:0], sub_ge};
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(S_W - 1);
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_state <= ST_SQRT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_SQRT: begin
                    r_srem <= sub_ge ? sub_diff[S_W+1:0] : sq_pre;
                    r_root <= sq_root_n;
                    r_y    <= {r_y[Q_W-3:0], 2'b00};
                    if (r_cnt == '0) begin
                        r_q     <= sq_round[S_W:1];
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid      <= 1'b1;
                        r_out.similarity <= sim;
                        r_out.zero_norm  <= r_zero;
                        r_state          <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/cosine_similarity_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity accumulator
// Streams element pairs of two vectors and returns their cosine similarity
// in signed Q1.16 on the pair marked last.
//
// Input channel: one element pair per transfer, a pair a cycle while
// accumulating. The pair marked last is summed in, the totals go to the
// normalise sequencer and the accumulators clear for the next vectors.
// Output channel: one result per vector pair. After the last input transfer
// the totals are handed over, a four-step limb multiplier forms the product
// of both sums of squares and then the squared dot product, and one compare,
// a 34-step divide, a 17-step square root and the loading of the result
// follow, the compare, divide and square root on one shared subtractor. A
// clamped result skips the divide and square root; when either vector has
// zero magnitude the sequencer goes straight to loading a zero result.
// o_in_stall is high from the cycle after the last transfer until the
// result sits in the output register. A stalled receiver holds the result
// there, and a following result waits in the sequencer.
// Reset (synchronous, active low) clears the accumulators and drops
// o_out_valid.
// ----------------------------------------------------------------------------
module cosine_similarity_accumulator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  csa_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output csa_pkg::t_out_item o_out_data
);
    import csa_pkg::*;

    t_acc_res acc_res;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    logic     core_busy;
    logic     in_take;

    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = core_busy || acc_res.start;

    csa_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_take),
        .i_item  (i_in_data),
        .o_res   (acc_res)
    );

    csa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    csa_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc_res),
        .o_mul       (mul_req),
        .i_mul       (mul_rsp),
        .o_busy      (core_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/csa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity accumulator - port checker
// Watches the top-level ports for result, stall and reset behaviour.
// ----------------------------------------------------------------------------
module csa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input csa_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input csa_pkg::t_out_item o_out_data
);
    import csa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left the block busy or a result pending");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_norm |-> o_out_data.similarity == '0)
        else $error("zero magnitude with a non-zero similarity");

    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.similarity <= SIM_ONE
                     && o_out_data.similarity >= -SIM_ONE)
        else $error("similarity out of range");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.last_elem |=> o_in_stall)
        else $error("input not stalled after the last pair");

endmodule

bind cosine_similarity_accumulator csa_checker u_csa_checker (.*);

// ===== bench/cosine_similarity_accumulator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity accumulator testbench
// Streams element pairs into the block with random gaps on the input side
// and random back-pressure on the output side. Each vector's Q1.16 cosine,
// predicted from exact integer sums or set in the plan, is compared field by
// field, in order. A short directed list covers the extremes, orthogonal
// vectors and zero magnitude. Random vectors of mixed shape and length follow.
// ----------------------------------------------------------------------------
module cosine_similarity_accumulator_tb;
    import csa_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 120;
    localparam int RANDOM_PAIRS = 1200;
    localparam int PLAN_ROWS    = 24;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [IN_W-1:0] ELEM_MIN = -(2 ** (IN_W - 1));
    localparam logic signed [IN_W-1:0] ELEM_MAX = 2 ** (IN_W - 1) - 1;

    typedef enum int {
        VEC_MIXED,
        VEC_SAME,
        VEC_NEGATED,
        VEC_SCALED,
        VEC_NEAR,
        VEC_ZERO_A,
        VEC_ZERO_B
    } t_vec_shape;

    typedef struct packed {
        logic signed [IN_W-1:0]  a;
        logic signed [IN_W-1:0]  b;
        logic                    last;
        logic                    typed;
        logic signed [OUT_W-1:0] sim;
        logic                    zn;
    } t_plan_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    t_out_item               similarity_due [$];
    t_out_item               awaited;
    logic signed [DOT_W-1:0] dot_sum;
    logic [SQ_W-1:0]         sq_a_sum;
    logic [SQ_W-1:0]         sq_b_sum;
    t_plan_row               plan [PLAN_ROWS];

    bit calm;
    int rx_hold;
    int cycle_count;
    int mismatches;
    int vectors_sent;
    int pairs_sent;
    int zero_norm_seen;
    int vector_len;
    int longest_vector;

    cosine_similarity_accumulator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [IN_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return ELEM_MIN;
            1: return ELEM_MAX;
            2: return '0;
            3: return IN_W'($signed($urandom_range(0, 16)) - 8);
            default: return IN_W'($urandom);
        endcase
    endfunction

    // Accumulate one pair; on the last pair work out the rounded cosine and clear.
    task automatic fold_pair(input t_in_item pair, output bit produced, output t_out_item res);
        logic signed [DOT_W-1:0] ea;
        logic signed [DOT_W-1:0] eb;
        logic [DOT_W-1:0]        mag;
        logic [255:0]            norm_prod;
        logic [255:0]            bound;
        logic [255:0]            trial;
        longint unsigned         q;
        longint unsigned         cand;
        longint unsigned         odd;
        bit                      neg;
        ea = $signed(pair.a_elem);
        eb = $signed(pair.b_elem);
        sq_a_sum = sq_a_sum + SQ_W'(ea * ea);
        sq_b_sum = sq_b_sum + SQ_W'(eb * eb);
        dot_sum  = dot_sum + ea * eb;
        produced = pair.last_elem;
        res = '0;
        if (pair.last_elem) begin
            if (sq_a_sum == '0 || sq_b_sum == '0) begin
                res.zero_norm = 1'b1;
            end else begin
                neg = dot_sum[DOT_W-1];
                mag = neg ? -dot_sum : dot_sum;
                norm_prod = 256'(sq_a_sum) * 256'(sq_b_sum);
                bound = (256'(mag) * 256'(mag)) << (2 * FRAC_BITS + 2);
                q = 0;
                // largest q with (2q-1)^2 * norm_prod <= 4 * dot^2 * 4^FRAC_BITS
                for (int bt = FRAC_BITS; bt >= 0; bt--) begin
                    cand = q | (64'd1 << bt);
                    if (cand <= SIM_ONE) begin
                        odd = 2 * cand - 1;
                        trial = 256'(odd) * 256'(odd) * norm_prod;
                        if (trial <= bound) q = cand;
                    end
                end
                res.similarity = neg ? OUT_W'(-q) : OUT_W'(q);
            end
            dot_sum  = '0;
            sq_a_sum = '0;
            sq_b_sum = '0;
        end
    endtask

    task automatic send_pair(input t_in_item pair, input t_out_item typed_due, input bit typed);
        int        gap;
        bit        produced;
        t_out_item res;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= pair;
        // hold the payload until the transfer
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        fold_pair(pair, produced, res);
        pairs_sent++;
        vector_len++;
        if (produced) begin
            similarity_due.insert(similarity_due.size(), typed ? typed_due : res);
            vectors_sent++;
            if (vector_len > longest_vector) longest_vector = vector_len;
            vector_len = 0;
        end
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (similarity_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        rx_hold     = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold != 0) begin
                rx_hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 3) == 0) rx_hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (o_out_data.zero_norm === 1'b1) zero_norm_seen++;
            if (similarity_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: similarity %0d zero_norm %0b",
                             o_out_data.similarity, o_out_data.zero_norm);
            end else begin
                awaited = similarity_due.pop_front();
                if (o_out_data.similarity !== awaited.similarity ||
                    o_out_data.zero_norm !== awaited.zero_norm) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch at cycle %0d: exp %0d/%0b got %0d/%0b",
                                 cycle_count, awaited.similarity, awaited.zero_norm,
                                 o_out_data.similarity, o_out_data.zero_norm);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_in_item   pair;
        t_out_item  hand;
        t_vec_shape shape;
        int         r;
        int         len;
        int         scale;
        int         random_goal;
        logic signed [IN_W-1:0] a;
        logic signed [IN_W-1:0] b;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        calm       = 1'b0;
        dot_sum    = '0;
        sq_a_sum   = '0;
        sq_b_sum   = '0;

        plan = '{
            '{'0,       '0,       1'b1, 1'b1, '0,       1'b1},
            '{5,        '0,       1'b1, 1'b1, '0,       1'b1},
            '{'0,       -7,       1'b1, 1'b1, '0,       1'b1},
            '{'0,       9,        1'b0, 1'b0, '0,       1'b0},
            '{'0,       -9,       1'b1, 1'b1, '0,       1'b1},
            '{ELEM_MAX, ELEM_MAX, 1'b1, 1'b1, SIM_ONE,  1'b0},
            '{ELEM_MIN, ELEM_MIN, 1'b1, 1'b1, SIM_ONE,  1'b0},
            '{ELEM_MIN, ELEM_MAX, 1'b1, 1'b1, -SIM_ONE, 1'b0},
            '{ELEM_MAX, ELEM_MIN, 1'b1, 1'b1, -SIM_ONE, 1'b0},
            '{1,        1,        1'b1, 1'b1, SIM_ONE,  1'b0},
            '{-1,       1,        1'b1, 1'b1, -SIM_ONE, 1'b0},
            '{1,        '0,       1'b0, 1'b0, '0,       1'b0},
            '{'0,       1,        1'b1, 1'b1, '0,       1'b0},
            '{3,        4,        1'b0, 1'b0, '0,       1'b0},
            '{4,        -3,       1'b1, 1'b1, '0,       1'b0},
            '{1,        1,        1'b0, 1'b0, '0,       1'b0},
            '{1,        '0,       1'b1, 1'b0, '0,       1'b0},
            '{'0,       '0,       1'b0, 1'b0, '0,       1'b0},
            '{2,        3,        1'b1, 1'b1, SIM_ONE,  1'b0},
            '{ELEM_MAX, ELEM_MIN, 1'b0, 1'b0, '0,       1'b0},
            '{ELEM_MIN, ELEM_MAX, 1'b0, 1'b0, '0,       1'b0},
            '{1234,     -2222,    1'b0, 1'b0, '0,       1'b0},
            '{-1,       1,        1'b1, 1'b0, '0,       1'b0},
            '{-5,       -5,       1'b1, 1'b1, SIM_ONE,  1'b0}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < PLAN_ROWS; k++) begin
            pair = '{a_elem: plan[k].a, b_elem: plan[k].b, last_elem: plan[k].last};
            hand = '{similarity: plan[k].sim, zero_norm: plan[k].zn};
            send_pair(pair, hand, plan[k].typed);
        end
        drain_results();

        hand = '0;
        calm = 1'b0;
        random_goal = pairs_sent + RANDOM_PAIRS;
        while (pairs_sent < random_goal) begin
            shape = t_vec_shape'($urandom_range(0, 6));
            r = $urandom_range(0, 49);
            len = r < 30 ? $urandom_range(1, 8) :
                  r < 48 ? $urandom_range(9, 32) : $urandom_range(64, 256);
            scale = $signed($urandom_range(0, 1000)) - 500;
            if ($urandom_range(0, 7) == 0) calm = ~calm;
            for (int i = 0; i < len; i++) begin
                a = rand_elem();
                case (shape)
                    VEC_SAME:    b = a;
                    VEC_NEGATED: b = -a;
                    VEC_SCALED: begin
                        a = IN_W'($signed($urandom_range(0, 128)) - 64);
                        b = IN_W'(a * scale);
                    end
                    VEC_NEAR:    b = a + IN_W'($signed($urandom_range(0, 6)) - 3);
                    VEC_ZERO_A: begin
                        a = '0;
                        b = rand_elem();
                    end
                    VEC_ZERO_B:  b = '0;
                    default:     b = rand_elem();
                endcase
                pair = '{a_elem: a, b_elem: b, last_elem: (i == len - 1)};
                send_pair(pair, hand, 1'b0);
            end
            if (vectors_sent % 16 == 5 || $urandom_range(0, 19) == 0) drain_results();
        end

        calm = 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (similarity_due.size() != 0)
            $display("%0d results never arrived", similarity_due.size());
        $display("Sent %0d vectors in %0d element pairs; %0d results had zero magnitude.",
                 vectors_sent, pairs_sent, zero_norm_seen);
        $display("Longest vector %0d pairs; random part under input gaps and output stalls.",
                 longest_vector);
        if (mismatches == 0 && similarity_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
